>>> hdl/accel_tilt_angles_defines.svh
// Assertion macros used by the tilt-angle top-level RTL file.
`ifndef ACCEL_TILT_ANGLES_DEFINES_SVH
`define ACCEL_TILT_ANGLES_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define ACCT_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define ACCT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> hdl/acctilt_pkg.sv
// Package: widths, stage payload types and the CORDIC angle table for the tilt-angle block.
`default_nettype none

package acctilt_pkg;

  // Number of CORDIC micro-rotations (12..24); the count is clamped at MAX_STEPS = 24
  localparam int CORDIC_STEPS = 16;
  localparam int MAX_STEPS    = 24;
  localparam int CORDIC_N     = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;

  // Sample and result widths
  localparam int IN_W  = 16;
  localparam int OUT_W = 15;

  // Radius preparation
  localparam int SQ_W   = 2 * IN_W - 1;   // one square, at most 2^30
  localparam int SUM_W  = 2 * IN_W;       // sum of two squares
  localparam int BLEN_W = 6;              // bit length 0..32
  localparam int RAD_W  = 62;             // normalised radicand
  localparam int KMAX   = 30;             // largest fractional shift
  localparam int K_W    = 5;
  localparam int ROOT_W = RAD_W / 2;      // one root bit per sqrt stage
  localparam int REM_W  = ROOT_W + 3;     // partial remainder
  localparam int NUM_W  = IN_W + KMAX;    // numerator scaled by 2^k

  // CORDIC datapath
  localparam int CW      = 48;            // x/y working width
  localparam int ANG_W   = 25;            // degrees * 2^16, signed
  localparam int FRAC    = 16;
  localparam int MAG_W   = 32;            // |angle| * 100
  localparam int CENTI_SCALE = 100;
  localparam int CENTI_LIMIT = 9000;
  localparam int ROUND_HALF  = 1 << (FRAC - 1);
  localparam int CENT_W  = MAG_W - FRAC;

  // Word leaving the radius front end
  typedef struct packed {
    logic                    vld;
    logic                    zero;
    logic [RAD_W-1:0]        rad;
    logic signed [NUM_W-1:0] num;
  } norm_t;

  // Word leaving the square-root pipeline
  typedef struct packed {
    logic                    vld;
    logic                    zero;
    logic [ROOT_W-1:0]       root;
    logic signed [NUM_W-1:0] num;
  } root_t;

  // atan(2^-i) in degrees * 2^16
  function automatic logic signed [ANG_W-1:0] atan_q16(input int unsigned idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      0:       v = 25'sd2949120;
      1:       v = 25'sd1740967;
      2:       v = 25'sd919879;
      3:       v = 25'sd466945;
      4:       v = 25'sd234379;
      5:       v = 25'sd117304;
      6:       v = 25'sd58666;
      7:       v = 25'sd29335;
      8:       v = 25'sd14668;
      9:       v = 25'sd7334;
      10:      v = 25'sd3667;
      11:      v = 25'sd1833;
      12:      v = 25'sd917;
      13:      v = 25'sd458;
      14:      v = 25'sd229;
      15:      v = 25'sd115;
      16:      v = 25'sd57;
      17:      v = 25'sd29;
      18:      v = 25'sd14;
      19:      v = 25'sd7;
      20:      v = 25'sd4;
      21:      v = 25'sd2;
      22:      v = 25'sd1;
      default: v = 25'sd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> hdl/acctilt_front.sv
// Radius front end: squares, normalising shift and numerator scaling (three stages).
`default_nettype none

module acctilt_front (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                en,
  input  wire logic                                vld_i,
  input  wire logic signed [acctilt_pkg::IN_W-1:0] num_i,
  input  wire logic signed [acctilt_pkg::IN_W-1:0] p_i,
  input  wire logic signed [acctilt_pkg::IN_W-1:0] q_i,
  output acctilt_pkg::norm_t                       norm_o
);
  import acctilt_pkg::*;

  // stage 1: squares
  logic                    vld1_r;
  logic                    zero1_r;
  logic [SQ_W-1:0]         pp1_r, qq1_r;
  logic signed [IN_W-1:0]  num1_r;
  logic signed [SUM_W-1:0] pp_full, qq_full;

  // stage 2: sum and shift amount
  logic                    vld2_r;
  logic                    zero2_r;
  logic [SUM_W-1:0]        s2_r;
  logic [K_W-1:0]          k2_r;
  logic signed [IN_W-1:0]  num2_r;
  logic [SUM_W-1:0]        s_nxt;
  logic [BLEN_W-1:0]       blen;
  logic [BLEN_W-1:0]       k_full;
  logic [K_W-1:0]          k_nxt;

  // stage 3: normalised word
  norm_t                   norm_r;
  logic [RAD_W-1:0]        rad_ext;
  logic signed [NUM_W-1:0] num_ext;

  assign pp_full = p_i * p_i;
  assign qq_full = q_i * q_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp1_r   <= pp_full[SQ_W-1:0];
      qq1_r   <= qq_full[SQ_W-1:0];
      num1_r  <= num_i;
      zero1_r <= (p_i == '0) && (q_i == '0) && (num_i == '0);
    end
  end

  // bit length of the radicand, then k = min(KMAX, (62 - len) / 2)
  always_comb begin
    s_nxt = SUM_W'(pp1_r) + SUM_W'(qq1_r);
    blen  = '0;
    for (int b = 0; b < SUM_W; b++) begin
      if (s_nxt[b]) blen = BLEN_W'(b + 1);
    end
    k_full = (BLEN_W'(RAD_W) - blen) >> 1;
    if (blen <= BLEN_W'(2)) begin
      k_nxt = K_W'(KMAX);
    end else begin
      k_nxt = k_full[K_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else if (en) begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r    <= s_nxt;
      k2_r    <= k_nxt;
      num2_r  <= num1_r;
      zero2_r <= zero1_r;
    end
  end

  // scale radicand by 2^2k and numerator by 2^k
  assign rad_ext = RAD_W'(s2_r);
  assign num_ext = NUM_W'(num2_r);

  // valid bit under reset, payload loaded whenever the pipeline moves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_r.vld <= 1'b0;
    end else if (en) begin
      norm_r.vld <= vld2_r;
    end
    if (en) begin
      norm_r.rad  <= rad_ext << {k2_r, 1'b0};
      norm_r.num  <= num_ext <<< k2_r;
      norm_r.zero <= zero2_r;
    end
  end

  assign norm_o = norm_r;

endmodule

`default_nettype wire

>>> hdl/acctilt_sqrt.sv
// Pipelined restoring square root: one root bit per stage.
`default_nettype none

module acctilt_sqrt (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire acctilt_pkg::norm_t norm_i,
  output acctilt_pkg::root_t      root_o
);
  import acctilt_pkg::*;

  logic                    vld_r   [ROOT_W];
  logic                    zero_r  [ROOT_W];
  logic [RAD_W-1:0]        rad_r   [ROOT_W];
  logic [REM_W-1:0]        rem_r   [ROOT_W];
  logic [ROOT_W-1:0]       root_r  [ROOT_W];
  logic signed [NUM_W-1:0] num_r   [ROOT_W];

  logic [RAD_W-1:0]        rad_nxt  [ROOT_W];
  logic [REM_W-1:0]        rem_nxt  [ROOT_W];
  logic [ROOT_W-1:0]       root_nxt [ROOT_W];

  // each stage brings down two radicand bits and tries one root bit
  always_comb begin
    logic [RAD_W-1:0]  rad_p;
    logic [REM_W-1:0]  rem_p;
    logic [ROOT_W-1:0] root_p;
    logic [REM_W-1:0]  cur;
    logic [REM_W-1:0]  trial;
    logic              ge;
    for (int j = 0; j < ROOT_W; j++) begin
      if (j == 0) begin
        rad_p  = norm_i.rad;
        rem_p  = '0;
        root_p = '0;
      end else begin
        rad_p  = rad_r[j-1];
        rem_p  = rem_r[j-1];
        root_p = root_r[j-1];
      end
      cur         = {rem_p[REM_W-3:0], rad_p[RAD_W-1 -: 2]};
      trial       = REM_W'({root_p, 2'b01});
      ge          = (cur >= trial);
      rad_nxt[j]  = rad_p << 2;
      rem_nxt[j]  = ge ? (cur - trial) : cur;
      root_nxt[j] = {root_p[ROOT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < ROOT_W; j++) vld_r[j] <= 1'b0;
    end else if (en) begin
      for (int j = 0; j < ROOT_W; j++) begin
        vld_r[j] <= (j == 0) ? norm_i.vld : vld_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < ROOT_W; j++) begin
        rad_r[j]  <= rad_nxt[j];
        rem_r[j]  <= rem_nxt[j];
        root_r[j] <= root_nxt[j];
        zero_r[j] <= (j == 0) ? norm_i.zero : zero_r[j-1];
        num_r[j]  <= (j == 0) ? norm_i.num  : num_r[j-1];
      end
    end
  end

  assign root_o.vld  = vld_r[ROOT_W-1];
  assign root_o.zero = zero_r[ROOT_W-1];
  assign root_o.root = root_r[ROOT_W-1];
  assign root_o.num  = num_r[ROOT_W-1];

endmodule

`default_nettype wire

>>> hdl/acctilt_cordic.sv
// Vectoring CORDIC pipeline with rounding to centidegrees and saturation.
`default_nettype none

module acctilt_cordic (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 en,
  input  wire logic                                 neg_i,
  input  wire acctilt_pkg::root_t                   root_i,
  output logic                                      vld_o,
  output logic signed [acctilt_pkg::OUT_W-1:0]      angle_o
);
  import acctilt_pkg::*;

  logic                    vld_r  [CORDIC_N];
  logic                    zero_r [CORDIC_N];
  logic signed [CW-1:0]    x_r    [CORDIC_N];
  logic signed [CW-1:0]    y_r    [CORDIC_N];
  logic signed [ANG_W-1:0] ang_r  [CORDIC_N];

  logic signed [CW-1:0]    x_nxt   [CORDIC_N];
  logic signed [CW-1:0]    y_nxt   [CORDIC_N];
  logic signed [ANG_W-1:0] ang_nxt [CORDIC_N];

  // scale stage
  logic                    mvld_r;
  logic                    mzero_r;
  logic                    mflip_r;
  logic [MAG_W-1:0]        mag_r;
  logic signed [ANG_W-1:0] ang_last;
  logic [ANG_W-1:0]        ang_abs;
  logic [MAG_W-1:0]        mag_nxt;

  // round stage
  logic                    vld_out_r;
  logic signed [OUT_W-1:0] angle_r;
  logic [MAG_W-1:0]        rnd;
  logic [CENT_W-1:0]       cent;
  logic [OUT_W-1:0]        cent_sat;
  logic signed [OUT_W-1:0] angle_nxt;

  // one micro-rotation per stage, driving y towards zero
  always_comb begin
    logic signed [CW-1:0]    x_p;
    logic signed [CW-1:0]    y_p;
    logic signed [ANG_W-1:0] a_p;
    logic signed [CW-1:0]    dx;
    logic signed [CW-1:0]    dy;
    for (int i = 0; i < CORDIC_N; i++) begin
      if (i == 0) begin
        x_p = CW'($signed({1'b0, root_i.root}));
        y_p = CW'(root_i.num);
        a_p = '0;
      end else begin
        x_p = x_r[i-1];
        y_p = y_r[i-1];
        a_p = ang_r[i-1];
      end
      dx = y_p >>> i;
      dy = x_p >>> i;
      if (!y_p[CW-1] && (y_p != '0)) begin
        x_nxt[i]   = x_p + dx;
        y_nxt[i]   = y_p - dy;
        ang_nxt[i] = a_p + atan_q16(i);
      end else begin
        x_nxt[i]   = x_p - dx;
        y_nxt[i]   = y_p + dy;
        ang_nxt[i] = a_p - atan_q16(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CORDIC_N; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      for (int i = 0; i < CORDIC_N; i++) begin
        vld_r[i] <= (i == 0) ? root_i.vld : vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < CORDIC_N; i++) begin
        x_r[i]    <= x_nxt[i];
        y_r[i]    <= y_nxt[i];
        ang_r[i]  <= ang_nxt[i];
        zero_r[i] <= (i == 0) ? root_i.zero : zero_r[i-1];
      end
    end
  end

  // |angle| * 100
  assign ang_last = ang_r[CORDIC_N-1];
  assign ang_abs  = ang_last[ANG_W-1] ? ANG_W'(-ang_last) : ANG_W'(ang_last);
  assign mag_nxt  = MAG_W'(ang_abs) * MAG_W'(CENTI_SCALE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mvld_r <= 1'b0;
    end else if (en) begin
      mvld_r <= vld_r[CORDIC_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r   <= mag_nxt;
      mzero_r <= zero_r[CORDIC_N-1];
      mflip_r <= ang_last[ANG_W-1] ^ neg_i;
    end
  end

  // round half away from zero, saturate, restore sign
  always_comb begin
    rnd  = mag_r + MAG_W'(ROUND_HALF);
    cent = rnd[MAG_W-1:FRAC];
    if (cent > CENT_W'(CENTI_LIMIT)) begin
      cent_sat = OUT_W'(CENTI_LIMIT);
    end else begin
      cent_sat = cent[OUT_W-1:0];
    end
    if (mzero_r) begin
      angle_nxt = '0;
    end else if (mflip_r) begin
      angle_nxt = -$signed(cent_sat);
    end else begin
      angle_nxt = $signed(cent_sat);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_out_r <= 1'b0;
    end else if (en) begin
      vld_out_r <= mvld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= angle_nxt;
    end
  end

  assign vld_o   = vld_out_r;
  assign angle_o = angle_r;

endmodule

`default_nettype wire

>>> hdl/accel_tilt_angles.sv
// Accelerometer tilt angles (roll and pitch) in centidegrees.
//
// Input channel in_*: one signed 16-bit sample (x, y, z) per word, taken at a
// rising edge with in_valid high and in_stall low. Output channel out_*: one
// word per sample with roll = atan2(y, |(x,z)|) and pitch = -atan2(x, |(y,z)|),
// both in 0.01 degree, saturated to +/-9000; an all-zero sample gives 0.
// From input acceptance to out_valid a sample passes 3 radius stages, 31
// square-root stages (one root bit each), one stage per CORDIC
// micro-rotation, scale, round and the output register. Throughput: one
// sample per cycle while in_stall is low, set by the fully pipelined
// datapath; the two angles run in parallel lanes.
// When out_stall holds a valid word, the pipeline keeps moving (bubbles
// collapse) until one more word lands in the skid register; only then does
// in_stall rise. in_stall is a registered signal.
// Reset (synchronous, rst_n low) clears all valid bits; the block holds no
// state between samples.
`default_nettype none
`include "accel_tilt_angles_defines.svh"

module accel_tilt_angles (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [acctilt_pkg::IN_W-1:0]  in_accel_x,
  input  wire logic signed [acctilt_pkg::IN_W-1:0]  in_accel_y,
  input  wire logic signed [acctilt_pkg::IN_W-1:0]  in_accel_z,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [acctilt_pkg::OUT_W-1:0]      out_roll_centideg,
  output logic signed [acctilt_pkg::OUT_W-1:0]      out_pitch_centideg
);
  import acctilt_pkg::*;

  logic                    en;
  norm_t                   roll_norm, pitch_norm;
  root_t                   roll_root, pitch_root;
  logic                    roll_vld, pitch_vld;
  logic signed [OUT_W-1:0] roll_c, pitch_c;

  // output register and skid word
  logic                    out_vld_r, out_vld_nxt;
  logic signed [OUT_W-1:0] out_roll_r, out_roll_nxt;
  logic signed [OUT_W-1:0] out_pitch_r, out_pitch_nxt;
  logic                    skid_vld_r, skid_vld_nxt;
  logic signed [OUT_W-1:0] skid_roll_r, skid_roll_nxt;
  logic signed [OUT_W-1:0] skid_pitch_r, skid_pitch_nxt;

  // pipeline advances whenever the skid word is free
  assign en       = !skid_vld_r;
  assign in_stall = skid_vld_r;

  // roll lane: atan2(y, |(x,z)|)
  acctilt_front u_roll_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (in_valid),
    .num_i  (in_accel_y),
    .p_i    (in_accel_x),
    .q_i    (in_accel_z),
    .norm_o (roll_norm)
  );

  acctilt_sqrt u_roll_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .norm_i (roll_norm),
    .root_o (roll_root)
  );

  acctilt_cordic u_roll_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .neg_i   (1'b0),
    .root_i  (roll_root),
    .vld_o   (roll_vld),
    .angle_o (roll_c)
  );

  // pitch lane: -atan2(x, |(y,z)|)
  acctilt_front u_pitch_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (in_valid),
    .num_i  (in_accel_x),
    .p_i    (in_accel_y),
    .q_i    (in_accel_z),
    .norm_o (pitch_norm)
  );

  acctilt_sqrt u_pitch_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .norm_i (pitch_norm),
    .root_o (pitch_root)
  );

  acctilt_cordic u_pitch_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .neg_i   (1'b1),
    .root_i  (pitch_root),
    .vld_o   (pitch_vld),
    .angle_o (pitch_c)
  );

  // output register with one-word skid
  always_comb begin
    out_vld_nxt    = out_vld_r;
    out_roll_nxt   = out_roll_r;
    out_pitch_nxt  = out_pitch_r;
    skid_vld_nxt   = skid_vld_r;
    skid_roll_nxt  = skid_roll_r;
    skid_pitch_nxt = skid_pitch_r;
    if (skid_vld_r) begin
      if (!out_stall) begin
        out_roll_nxt  = skid_roll_r;
        out_pitch_nxt = skid_pitch_r;
        skid_vld_nxt  = 1'b0;
      end
    end else if (out_vld_r && out_stall) begin
      skid_vld_nxt   = roll_vld;
      skid_roll_nxt  = roll_c;
      skid_pitch_nxt = pitch_c;
    end else begin
      out_vld_nxt   = roll_vld;
      out_roll_nxt  = roll_c;
      out_pitch_nxt = pitch_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_roll_r   <= out_roll_nxt;
    out_pitch_r  <= out_pitch_nxt;
    skid_roll_r  <= skid_roll_nxt;
    skid_pitch_r <= skid_pitch_nxt;
  end

  assign out_valid          = out_vld_r;
  assign out_roll_centideg  = out_roll_r;
  assign out_pitch_centideg = out_pitch_r;

  // checks
  `ACCT_ASSERT(a_lanes_lockstep, roll_vld == pitch_vld, "roll and pitch lanes out of step")
  `ACCT_ASSERT(a_skid_behind_out, !skid_vld_r || out_vld_r, "skid word held with empty output")
  `ACCT_ASSERT(a_roll_range, !out_vld_r || ((out_roll_r >= -15'sd9000) && (out_roll_r <= 15'sd9000)), "roll out of range")
  `ACCT_ASSERT(a_pitch_range, !out_vld_r || ((out_pitch_r >= -15'sd9000) && (out_pitch_r <= 15'sd9000)), "pitch out of range")
  `ACCT_ASSERT_IMPL(a_stall_cause, $rose(skid_vld_r), $past(out_vld_r && out_stall), "input stalled without output stall")

endmodule

`default_nettype wire
